>>> hdl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types, character codes and helpers for the comment-stripping
// line reader.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int MAX_LINE = 64;
  localparam int LEN_W    = $clog2(MAX_LINE + 1);
  localparam int ADDR_W   = $clog2(MAX_LINE);

  localparam logic [7:0] CH_QUOTE     = 8'd34;
  localparam logic [7:0] CH_SLASH     = 8'd47;
  localparam logic [7:0] CH_STAR      = 8'd42;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_IN_BLOCK = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             char_valid;
    logic             last_of_line;
    logic [LEN_W-1:0] line_length;
    logic [1:0]       line_status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELOAD_RD,
    S_RELOAD_CAP,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_t;

  // What an accepted beat asks of the sequencer
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RELOAD,
    ACT_EMIT_TRIM,
    ACT_EMIT_RAW
  } action_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_TRIM,
    RD_EMIT
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    reload_cap;
    logic    trim_dec;
    logic    emit_load;
    logic    k_inc;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    len_zero;
    logic    rdata_space;
    logic    emit_last;
    logic    out_free;
  } status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

>>> hdl/clr_ctrl.sv
// ----------------------------------------------------------------------------
// clr_ctrl
// Sequencer: takes beats, reloads the last stored character after a removal,
// walks back over trailing whitespace and then walks the line out.
// ----------------------------------------------------------------------------
module clr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  clr_pkg::status_t sts,
  output clr_pkg::cmd_t   cmd
);
  import clr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (sts.act)
            ACT_NONE:      state_next = S_IDLE;
            ACT_RELOAD:    state_next = S_RELOAD_RD;
            ACT_EMIT_TRIM: state_next = S_TRIM_RD;
            ACT_EMIT_RAW:  state_next = S_EMIT_RD;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_RELOAD_RD:  state_next = S_RELOAD_CAP;
      S_RELOAD_CAP: state_next = S_IDLE;
      S_TRIM_RD:    state_next = sts.len_zero ? S_EMIT_PUT : S_TRIM_CHK;
      S_TRIM_CHK:   state_next = sts.rdata_space ? S_TRIM_RD : S_EMIT_RD;
      S_EMIT_RD:    state_next = S_EMIT_PUT;
      S_EMIT_PUT: begin
        if (sts.out_free) begin
          state_next = (sts.len_zero || sts.emit_last) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_LAST;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_RELOAD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
      end
      S_RELOAD_CAP: cmd.reload_cap = 1'b1;
      S_TRIM_RD: begin
        cmd.rd_en  = !sts.len_zero;
        cmd.rd_sel = RD_TRIM;
      end
      S_TRIM_CHK: cmd.trim_dec = sts.rdata_space;
      S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_EMIT;
      end
      S_EMIT_PUT: begin
        cmd.emit_load = sts.out_free;
        cmd.k_inc     = sts.out_free && !sts.emit_last && !sts.len_zero;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/clr_datapath.sv
// ----------------------------------------------------------------------------
// clr_datapath
// Line store, lexer flags, fill count, beat decode and the output register.
// ----------------------------------------------------------------------------
module clr_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  clr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output clr_pkg::out_item_t        out_data,
  input  logic                      cfg_write,
  input  logic [clr_pkg::LEN_W-1:0] cfg_data,
  input  clr_pkg::cmd_t             cmd,
  output clr_pkg::status_t          sts
);
  import clr_pkg::*;

  localparam logic [LEN_W-1:0] LIM_HI = LEN_W'(MAX_LINE);
  localparam logic [LEN_W-1:0] LIM_LO = LEN_W'(2);

  logic [7:0]        mem [MAX_LINE];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] rd_addr;

  logic [LEN_W-1:0]  max_length;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  fill;
  logic [7:0]        last_char;
  logic              blk, quoted, pws, skip, drop;

  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] k;
  logic [1:0]        emit_status;

  // decode of the beat on offer
  action_t           act;
  logic [LEN_W-1:0]  d_len;
  logic [1:0]        d_status;
  logic              d_write;
  logic [LEN_W-1:0]  fill_next;
  logic              blk_next, quoted_next, pws_next, skip_next, drop_next;

  logic [7:0]        ch;
  logic              last_slash, last_bslash;

  assign ch          = in_data.in_byte;
  assign last_slash  = (fill != '0) && (last_char == CH_SLASH);
  assign last_bslash = (fill != '0) && (last_char == CH_BACKSLASH);

  always_comb begin
    if (max_length < LIM_LO) lim = LIM_LO;
    else if (max_length > LIM_HI) lim = LIM_HI;
    else lim = max_length;
  end

  always_comb begin
    act         = ACT_NONE;
    d_len       = '0;
    d_status    = STATUS_OK;
    d_write     = 1'b0;
    fill_next   = fill;
    blk_next    = blk;
    quoted_next = quoted;
    pws_next    = pws;
    skip_next   = skip;
    drop_next   = drop;
    if (in_data.end_of_input) begin
      act       = ACT_EMIT_TRIM;
      d_len     = drop ? '0 : fill;
      d_status  = (!drop && blk) ? STATUS_IN_BLOCK : STATUS_OK;
      drop_next = 1'b0;
    end else if (drop) begin
      if (ch == CH_LF) begin
        drop_next = 1'b0;
        skip_next = 1'b1;
      end
    end else if (!(skip && is_space(ch))) begin
      skip_next = 1'b0;
      if (blk) begin
        if (pws && ch == CH_SLASH) begin
          blk_next  = 1'b0;
          pws_next  = 1'b0;
          skip_next = 1'b1;
        end else begin
          pws_next = (ch == CH_STAR);
        end
      end else if (!quoted && ch == CH_SLASH && last_slash) begin
        // line comment: emit what stands before the first slash
        act       = ACT_EMIT_TRIM;
        d_len     = fill - LEN_W'(1);
        drop_next = 1'b1;
      end else if (!quoted && ch == CH_STAR && last_slash) begin
        act       = ACT_RELOAD;
        fill_next = fill - LEN_W'(1);
        blk_next  = 1'b1;
        pws_next  = 1'b0;
      end else begin
        if (ch == CH_QUOTE) quoted_next = !quoted;
        if (ch == CH_CR) begin
          act = ACT_NONE;
        end else if (ch == CH_LF) begin
          if (last_bslash) begin
            act       = ACT_RELOAD;
            fill_next = fill - LEN_W'(1);
            skip_next = 1'b1;
          end else begin
            act   = ACT_EMIT_TRIM;
            d_len = fill;
          end
        end else if (fill < lim) begin
          d_write   = 1'b1;
          fill_next = fill + LEN_W'(1);
        end else begin
          act       = ACT_EMIT_RAW;
          d_len     = lim - LEN_W'(1);
          d_status  = STATUS_OVERFLOW;
          drop_next = 1'b1;
        end
      end
    end
    // any emission starts the next line afresh
    if (act == ACT_EMIT_TRIM || act == ACT_EMIT_RAW) begin
      fill_next   = '0;
      blk_next    = 1'b0;
      quoted_next = 1'b0;
      pws_next    = 1'b0;
      skip_next   = !drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LEN_W'(MAX_LINE);
    end else if (cfg_write) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      blk    <= 1'b0;
      quoted <= 1'b0;
      pws    <= 1'b0;
      skip   <= 1'b1;
      drop   <= 1'b0;
    end else if (cmd.accept) begin
      fill   <= fill_next;
      blk    <= blk_next;
      quoted <= quoted_next;
      pws    <= pws_next;
      skip   <= skip_next;
      drop   <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && d_write) begin
      mem[fill[ADDR_W-1:0]] <= ch;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    rd_addr = '0;
    case (cmd.rd_sel)
      RD_LAST: rd_addr = ADDR_W'(fill - LEN_W'(1));
      RD_TRIM: rd_addr = ADDR_W'(len - LEN_W'(1));
      RD_EMIT: rd_addr = k;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && d_write) begin
      last_char <= ch;
    end else if (cmd.reload_cap) begin
      last_char <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len         <= d_len;
      emit_status <= d_status;
      k           <= '0;
    end else begin
      if (cmd.trim_dec) len <= len - LEN_W'(1);
      if (cmd.k_inc) k <= k + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      if (sts.len_zero) begin
        out_data <= '{out_char: 8'd0, char_valid: 1'b0, last_of_line: 1'b1,
                      line_length: '0, line_status: emit_status};
      end else begin
        out_data <= '{out_char: rdata, char_valid: 1'b1, last_of_line: sts.emit_last,
                      line_length: len, line_status: emit_status};
      end
    end
  end

  assign sts.act         = act;
  assign sts.len_zero    = (len == '0);
  assign sts.rdata_space = is_space(rdata);
  assign sts.emit_last   = ({1'b0, k} == (len - LEN_W'(1)));
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

>>> hdl/comment_stripping_line_reader.sv
// ----------------------------------------------------------------------------
// comment_stripping_line_reader
// Gathers text bytes into logical lines with comments, CR and surrounding
// whitespace removed, and hands each line out one character per beat.
// ----------------------------------------------------------------------------
// A byte that does not finish a line is taken in while the reader is idle, so
// such bytes stream at one per cycle. A byte that removes the last stored
// character (the slash opening a block comment, or a backslash joined to the
// next line) passes through RELOAD_RD and RELOAD_CAP, as the new last
// character is read back from the line store. A byte that ends a line starts
// the trim walk, which reads back from the end, drops trailing whitespace and
// stops at a kept character, or for an empty line goes to its single beat;
// each character is then read and put out in turn, holding while the output
// is stalled. An overflowing line is emitted untrimmed, with no trim walk.
// The single read port of the line store is walked once for the trim and
// once for the emission. Input is stalled while a line is being walked out.
// ----------------------------------------------------------------------------
module comment_stripping_line_reader (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  clr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output clr_pkg::out_item_t        out_data,
  input  logic                      cfg_write,
  input  logic [clr_pkg::LEN_W-1:0] cfg_data
);
  import clr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the comment-stripping line reader. Byte beats go in
// from a queue with random gaps and the result side stalls at random. Every
// accepted byte runs through a behavioural copy of the line reader that
// queues the characters it should emit. Each result beat is checked field by
// field against the oldest of them. A short directed run comes first, then
// random lines under a range of max_length settings.
// ----------------------------------------------------------------------------
module tb_top;
  import clr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_write;
  logic [LEN_W-1:0]   cfg_data;

  // behavioural copy of the reader state
  logic [7:0]         line_copy [MAX_LINE];
  int unsigned        line_fill;
  bit                 in_block;
  bit                 in_quote;
  bit                 star_seen;
  bit                 skip_lead;
  bit                 drop_rest;
  logic [LEN_W-1:0]   max_len_reg;

  in_item_t           pending_bytes [$];
  out_item_t          expected_chars [$];

  int                 bytes_sent;
  int                 accepted_count;
  int                 mismatches;
  int                 in_gap;
  int                 stall_left;
  int                 calm_left;
  int                 quiet_cycles;
  bit                 in_taken;

  comment_stripping_line_reader uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic int line_cap();
    int m;
    m = max_len_reg;
    if (m < 2) m = 2;
    if (m > MAX_LINE) m = MAX_LINE;
    return m;
  endfunction

  function automatic bit ends_with(logic [7:0] c);
    return line_fill > 0 && line_fill <= MAX_LINE && line_copy[line_fill - 1] == c;
  endfunction

  function automatic void restart_line();
    line_fill = 0;
    in_block  = 1'b0;
    in_quote  = 1'b0;
    star_seen = 1'b0;
    skip_lead = 1'b1;
    drop_rest = 1'b0;
  endfunction

  function automatic void emit_line(int n, logic [1:0] status, bit trim);
    int        len;
    out_item_t r;
    len = (n > MAX_LINE) ? MAX_LINE : n;
    if (trim) begin
      while (len > 0 && blank(line_copy[len - 1])) len--;
    end
    restart_line();
    r = '0;
    r.last_of_line = 1'b1;
    r.line_status  = status;
    // an empty line still takes one beat, with char_valid low
    if (len == 0) expected_chars.push_back(r);
    for (int k = 0; k < len; k++) begin
      r.out_char     = line_copy[k];
      r.char_valid   = 1'b1;
      r.last_of_line = (k == len - 1);
      r.line_length  = LEN_W'(len);
      expected_chars.push_back(r);
    end
  endfunction

  function automatic void predict_line(in_item_t beat);
    logic [7:0] ch;
    ch = beat.in_byte;
    if (beat.end_of_input) begin
      if (drop_rest) emit_line(0, STATUS_OK, 1'b1);
      else emit_line(line_fill, in_block ? STATUS_IN_BLOCK : STATUS_OK, 1'b1);
      return;
    end
    if (drop_rest) begin
      if (ch == CH_LF) begin
        drop_rest = 1'b0;
        skip_lead = 1'b1;
      end
      return;
    end
    if (skip_lead) begin
      if (blank(ch)) return;
      skip_lead = 1'b0;
    end
    if (in_block) begin
      if (star_seen && ch == CH_SLASH) begin
        in_block  = 1'b0;
        star_seen = 1'b0;
        skip_lead = 1'b1;
      end else begin
        star_seen = (ch == CH_STAR);
      end
      return;
    end
    if (!in_quote) begin
      if (ch == CH_QUOTE) begin
        in_quote = 1'b1;
      end else if (ch == CH_SLASH && ends_with(CH_SLASH)) begin
        // line comment: the first slash is already stored, drop it
        emit_line(line_fill - 1, STATUS_OK, 1'b1);
        skip_lead = 1'b0;
        drop_rest = 1'b1;
        return;
      end else if (ch == CH_STAR && ends_with(CH_SLASH)) begin
        line_fill--;
        in_block  = 1'b1;
        star_seen = 1'b0;
        return;
      end
    end else if (ch == CH_QUOTE) begin
      in_quote = 1'b0;
    end
    if (ch == CH_CR) return;
    if (ch == CH_LF) begin
      if (ends_with(CH_BACKSLASH)) begin
        line_fill--;
        skip_lead = 1'b1;
      end else begin
        emit_line(line_fill, STATUS_OK, 1'b1);
      end
      return;
    end
    if (line_fill < line_cap()) begin
      line_copy[line_fill % MAX_LINE] = ch;
      line_fill++;
    end else begin
      emit_line(line_cap() - 1, STATUS_OVERFLOW, 1'b0);
      skip_lead = 1'b0;
      drop_rest = 1'b1;
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly short gaps, the odd long one, none at all during a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    in_item_t beat;
    beat.in_byte      = b;
    beat.end_of_input = 1'b0;
    pending_bytes.push_back(beat);
    bytes_sent++;
  endfunction

  function automatic void push_text(string text);
    for (int i = 0; i < text.len(); i++) push_byte(text[i]);
  endfunction

  function automatic void push_eof();
    in_item_t beat;
    beat.in_byte      = 8'($urandom_range(0, 255));
    beat.end_of_input = 1'b1;
    pending_bytes.push_back(beat);
    bytes_sent++;
  endfunction

  function automatic void push_word(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(33, 126)));
  endfunction

  function automatic void push_random_line(int cap);
    int pieces;
    pieces = $urandom_range(1, 5);
    if ($urandom_range(0, 3) == 0) push_text(" \t");
    repeat (pieces) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: push_word($urandom_range(1, 6));
        5, 6: begin
          repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        end
        7: begin
          push_byte(CH_QUOTE);
          push_word($urandom_range(0, 3));
          if ($urandom_range(0, 1)) push_text("//");
          push_byte(CH_QUOTE);
        end
        8: begin
          push_text("//");
          push_word($urandom_range(0, 4));
        end
        9: begin
          push_text("/*");
          push_word($urandom_range(0, 3));
          if ($urandom_range(0, 1)) push_byte(CH_LF);
          push_byte(CH_STAR);
          push_text("*/");
        end
        10: begin
          push_byte(CH_BACKSLASH);
          push_byte(CH_LF);
        end
        11: push_byte(CH_CR);
        12, 13: push_byte(8'($urandom_range(0, 255)));
        14: begin
          // long run around the limit, to land either side of overflow
          if ($urandom_range(0, 2) == 0) push_word($urandom_range(cap - 2, cap + 2));
          else push_word(2);
        end
        default: push_text(" /");
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_text("  ");
    push_byte(CH_LF);
  endfunction

  task automatic wait_line_drain();
    do @(negedge clk); while (accepted_count != bytes_sent || expected_chars.size() != 0);
    // a byte that opens a comment is still being taken in after the last result
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    max_len_reg = v;
    @(posedge clk);
  endtask

  always @(negedge clk) begin : feed_bytes
    bit next_valid;
    if (!rst) begin
      next_valid = in_valid;
      if (in_valid && in_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          in_data    <= pending_bytes.pop_front();
          next_valid = 1'b1;
          in_gap     = pick_gap();
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : watch_beats
    out_item_t want;
    bit        out_taken;
    if (rst) begin
      in_taken     = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (out_taken) begin
        if (expected_chars.size() == 0) begin
          $error("result beat with nothing expected: out_char %0d", out_data.out_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          compare_field("out_char", want.out_char, out_data.out_char);
          compare_field("char_valid", 8'(want.char_valid), 8'(out_data.char_valid));
          compare_field("last_of_line", 8'(want.last_of_line),
                        8'(out_data.last_of_line));
          compare_field("line_length", 8'(want.line_length), 8'(out_data.line_length));
          compare_field("line_status", 8'(want.line_status), 8'(out_data.line_status));
        end
      end
      if (in_taken) begin
        accepted_count++;
        predict_line(in_data);
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(20, 80);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int plan [6];
    int half_mark;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    max_len_reg = LEN_W'(MAX_LINE);
    restart_line();

    // leading blanks, CR, backslash join, quoted slashes, line comment,
    // block comment over a newline, comment at line start, EOF while dropping
    push_byte(CH_SPACE);
    push_byte(CH_TAB);
    push_text("x");
    push_byte(CH_CR);
    push_byte(CH_BACKSLASH);
    push_byte(CH_LF);
    push_text("\"//\"//c");
    push_byte(CH_LF);
    push_text("/*");
    push_byte(CH_LF);
    push_text("*/b");
    push_byte(CH_LF);
    push_text("//");
    push_eof();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_line_drain();

    // byte extremes, overflow at the smallest limit, EOF inside a block comment
    write_max_len(LEN_W'(2));
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("c");
    push_byte(CH_LF);
    push_text("/*");
    push_eof();
    wait_line_drain();

    plan = '{0, 127, 1, 65, int'($urandom_range(3, 63)), 64};
    foreach (plan[p]) begin
      write_max_len(LEN_W'(plan[p]));
      half_mark = bytes_sent + 17;
      while (bytes_sent < half_mark) push_random_line(line_cap());
      // hold the sender back once until everything has come out
      if (p == 2) wait_line_drain();
      while (bytes_sent < half_mark + 17) push_random_line(line_cap());
      if ($urandom_range(0, 2) == 0) push_text("/*");
      push_eof();
      wait_line_drain();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/clr_pkg.sv
hdl/clr_ctrl.sv
hdl/clr_datapath.sv
hdl/comment_stripping_line_reader.sv
verif/tb_top.sv
